FILE: design/pts_pkg.sv
// Shared types, constants and helpers of the pose transform and standoff setpoint block.
package pts_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned SQRT_STEPS  = 32;
  localparam int unsigned DIV_STEPS   = 23;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 23;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STANDOFF   = 2'd0,
    CFG_FWD_OFFSET = 2'd1,
    CFG_UP_OFFSET  = 2'd2
  } pts_cfg_idx_e;

  localparam logic [22:0]        STANDOFF_RST = 23'd196608;
  localparam logic signed [17:0] FWD_RST      = 18'sd13107;
  localparam logic signed [17:0] UP_RST       = 18'sd1966;
  localparam logic signed [33:0] ONE_Q28      = 34'sd268435456;

  typedef struct packed {
    logic [22:0]        standoff;
    logic signed [17:0] fwd;
    logic signed [17:0] up;
  } pts_cfg_t;

  typedef struct packed {
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic signed [31:0] robot_z;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] cam_point_x;
    logic signed [31:0] cam_point_y;
    logic signed [31:0] cam_point_z;
  } pts_in_t;

  typedef struct packed {
    logic signed [31:0] target_world_x;
    logic signed [31:0] target_world_y;
    logic signed [31:0] target_world_z;
    logic signed [31:0] setpoint_x;
    logic signed [31:0] setpoint_y;
    logic signed [31:0] setpoint_z;
    logic               zero_distance;
  } pts_out_t;

  // One queued item: robot position, body-frame point and rotation matrix in Q.28.
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][32:0] b;
    logic [8:0][33:0] rm;
  } pts_work_t;

  function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
    if (v > 43'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -43'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

FILE: design/pts_front.sv
// Front stage: accepts an item, forms the body-frame point and the rotation matrix.
module pts_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pts_pkg::pts_cfg_t     cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pts_pkg::pts_in_t      in_data_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output pts_pkg::pts_work_t    push_data_o
);

  logic               vld_q;
  pts_pkg::pts_work_t ent_q, ent_d;

  logic signed [15:0] qx, qy, qz, qw;
  logic signed [31:0] pxx, pyy, pzz, pxy, pxz, pyz, pxw, pyw, pzw;
  logic signed [33:0] rm [9];
  logic signed [32:0] b0, b1, b2;

  always_comb begin
    qx  = $signed(in_data_i.quat_x);
    qy  = $signed(in_data_i.quat_y);
    qz  = $signed(in_data_i.quat_z);
    qw  = $signed(in_data_i.quat_w);
    pxx = qx * qx;
    pyy = qy * qy;
    pzz = qz * qz;
    pxy = qx * qy;
    pxz = qx * qz;
    pyz = qy * qz;
    pxw = qx * qw;
    pyw = qy * qw;
    pzw = qz * qw;
    rm[0] = pts_pkg::ONE_Q28 - ((pyy + pzz) <<< 1);
    rm[1] = (pxy - pzw) <<< 1;
    rm[2] = (pxz + pyw) <<< 1;
    rm[3] = (pxy + pzw) <<< 1;
    rm[4] = pts_pkg::ONE_Q28 - ((pxx + pzz) <<< 1);
    rm[5] = (pyz - pxw) <<< 1;
    rm[6] = (pxz - pyw) <<< 1;
    rm[7] = (pyz + pxw) <<< 1;
    rm[8] = pts_pkg::ONE_Q28 - ((pxx + pyy) <<< 1);
    // Fixed camera mount: optical z is body forward, optical x and y point right and down.
    b0 = $signed(in_data_i.cam_point_z) + $signed(cfg_i.fwd);
    b1 = -$signed(in_data_i.cam_point_x);
    b2 = $signed(cfg_i.up) - $signed(in_data_i.cam_point_y);
    ent_d.pos[0] = in_data_i.robot_x;
    ent_d.pos[1] = in_data_i.robot_y;
    ent_d.pos[2] = in_data_i.robot_z;
    ent_d.b[0]   = b0;
    ent_d.b[1]   = b1;
    ent_d.b[2]   = b2;
    for (int k = 0; k < 9; k++) begin
      ent_d.rm[k] = rm[k];
    end
  end

  assign in_ready_o   = !vld_q || push_ready_i;
  assign push_valid_o = vld_q;
  assign push_data_o  = ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ent_q <= ent_d;
    end
  end

endmodule

FILE: design/pts_fifo.sv
// Small queue that decouples the front stage from the arithmetic pipeline.
module pts_fifo #(
  parameter int unsigned Depth = pts_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  pts_pkg::pts_work_t push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output pts_pkg::pts_work_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  pts_pkg::pts_work_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    cnt_q;
  logic               push, pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: design/pts_back.sv
// Back pipeline: rotation, distance, square root, pullback division and output register.
module pts_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pts_pkg::pts_cfg_t  cfg_i,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  pts_pkg::pts_work_t pop_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pts_pkg::pts_out_t  out_data_o
);

  localparam int unsigned SqSteps  = pts_pkg::SQRT_STEPS;
  localparam int unsigned DivSteps = pts_pkg::DIV_STEPS;
  localparam int unsigned NumStg   = 7 + SqSteps + 1 + DivSteps + 1;
  localparam logic signed [69:0] RoundQ28 = 70'sd134217728;

  typedef struct packed {
    logic [2:0][31:0] tw;
    logic [1:0]       neg;
    logic             zero;
    logic [1:0][53:0] num;
  } sq_side_t;

  typedef struct packed {
    logic [2:0][31:0] tw;
    logic [1:0]       neg;
    logic             skip;
    logic [32:0]      dv;
  } dv_side_t;

  logic              en;
  logic [NumStg-1:0] vld_q;

  // The whole pipeline advances together unless a finished item waits at the output.
  assign en          = !out_valid_o || out_ready_i;
  assign pop_ready_o = en;
  assign out_valid_o = vld_q[NumStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStg-2:0], pop_valid_i};
    end
  end

  // Products of the matrix with the high and low halves of the body vector.
  logic signed [50:0] phi_q [3][3];
  logic signed [50:0] plo_q [3][3];
  logic [31:0]        pos_q [4][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          phi_q[i][j] <= $signed(pop_data_i.rm[i*3+j]) * $signed(pop_data_i.b[j][32:16]);
          plo_q[i][j] <= $signed(pop_data_i.rm[i*3+j]) *
                         $signed({1'b0, pop_data_i.b[j][15:0]});
        end
        pos_q[0][i] <= pop_data_i.pos[i];
      end
      for (int s = 1; s < 4; s++) begin
        for (int i = 0; i < 3; i++) begin
          pos_q[s][i] <= pos_q[s-1][i];
        end
      end
    end
  end

  logic signed [52:0] hi_q [3];
  logic signed [52:0] lo_q [3];
  logic signed [69:0] acc  [3];
  logic signed [41:0] rot_q [3];
  logic signed [42:0] twx  [3];
  logic [31:0]        tw_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = $signed({hi_q[i], 16'h0000}) + lo_q[i] + RoundQ28;
      twx[i] = rot_q[i] + $signed(pos_q[2][i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hi_q[i]  <= phi_q[i][0] + phi_q[i][1] + phi_q[i][2];
        lo_q[i]  <= plo_q[i][0] + plo_q[i][1] + plo_q[i][2];
        rot_q[i] <= acc[i][69:28];
        tw_q[i]  <= pts_pkg::sat32(twx[i]);
      end
    end
  end

  // Distance vector, magnitudes and the halving for very large distances.
  logic signed [32:0] dd   [3];
  logic [32:0]        mag  [3];
  logic               big, zero_c;
  logic [30:0]        m_q  [3];
  logic [1:0]         neg_q [2];
  logic               zero_q [2];
  logic [31:0]        twd_q [2][3];
  logic [61:0]        sqr_q [3];
  logic [53:0]        num_q [2];
  logic [63:0]        sum_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd[i]  = $signed(tw_q[i]) - $signed(pos_q[3][i]);
      mag[i] = dd[i][32] ? 33'(-dd[i]) : 33'(dd[i]);
    end
    zero_c = (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
    big    = (mag[0][32:31] != '0) || (mag[1][32:31] != '0) || (mag[2][32:31] != '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_q[i]      <= big ? mag[i][31:1] : mag[i][30:0];
        twd_q[0][i] <= tw_q[i];
        twd_q[1][i] <= twd_q[0][i];
        sqr_q[i]    <= m_q[i] * m_q[i];
      end
      neg_q[0]  <= {dd[1][32], dd[0][32]};
      neg_q[1]  <= neg_q[0];
      zero_q[0] <= zero_c;
      zero_q[1] <= zero_q[0];
      num_q[0]  <= cfg_i.standoff * m_q[0];
      num_q[1]  <= cfg_i.standoff * m_q[1];
      sum_q     <= 64'(sqr_q[0]) + 64'(sqr_q[1]) + 64'(sqr_q[2]);
    end
  end

  sq_side_t side_f_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_f_q.tw[0]  <= twd_q[1][0];
      side_f_q.tw[1]  <= twd_q[1][1];
      side_f_q.tw[2]  <= twd_q[1][2];
      side_f_q.neg    <= neg_q[1];
      side_f_q.zero   <= zero_q[1];
      side_f_q.num[0] <= num_q[0];
      side_f_q.num[1] <= num_q[1];
    end
  end

  // Integer square root, two radicand bits per stage.
  logic [31:0] sroot_q [SqSteps];
  sq_side_t    sside_q [SqSteps];
  logic [63:0] sv_q    [SqSteps-1];
  logic [33:0] srem_q  [SqSteps-1];

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    logic [63:0] v_in;
    logic [33:0] rem_in, rem_nx;
    logic [31:0] root_in, root_nx;
    sq_side_t    side_in;
    logic [35:0] cur, trial;

    if (k == 0) begin : g_first
      assign v_in    = sum_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_f_q;
    end else begin : g_next
      assign v_in    = sv_q[k-1];
      assign rem_in  = srem_q[k-1];
      assign root_in = sroot_q[k-1];
      assign side_in = sside_q[k-1];
    end

    always_comb begin
      cur   = {rem_in, v_in[63:62]};
      trial = {2'b00, root_in, 2'b01};
      if (cur >= trial) begin
        rem_nx  = 34'(cur - trial);
        root_nx = {root_in[30:0], 1'b1};
      end else begin
        rem_nx  = cur[33:0];
        root_nx = {root_in[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sroot_q[k] <= root_nx;
        sside_q[k] <= side_in;
      end
    end

    if (k < SqSteps - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en) begin
          sv_q[k]   <= {v_in[61:0], 2'b00};
          srem_q[k] <= rem_nx;
        end
      end
    end
  end

  // Division setup: quotient is floor((2*num + norm) / (2*norm)).
  logic [31:0]      nrm;
  logic [1:0][55:0] grem_q;
  dv_side_t         gside_q;

  assign nrm = sroot_q[SqSteps-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        grem_q[l] <= {1'b0, sside_q[SqSteps-1].num[l], 1'b0} + 56'(nrm);
      end
      gside_q.tw   <= sside_q[SqSteps-1].tw;
      gside_q.neg  <= sside_q[SqSteps-1].neg;
      gside_q.skip <= sside_q[SqSteps-1].zero || (nrm == '0);
      gside_q.dv   <= {nrm, 1'b0};
    end
  end

  // Restoring division, one quotient bit per stage for both lanes.
  logic [1:0][22:0] dq_q    [DivSteps];
  dv_side_t         dside_q [DivSteps];
  logic [1:0][55:0] drem_q  [DivSteps-1];

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    localparam int unsigned Bit = DivSteps - 1 - k;
    logic [1:0][55:0] rem_in, rem_nx;
    logic [1:0][22:0] q_in, q_nx;
    dv_side_t         side_in;
    logic [55:0]      sh;

    if (k == 0) begin : g_first
      assign rem_in  = grem_q;
      assign q_in    = '0;
      assign side_in = gside_q;
    end else begin : g_next
      assign rem_in  = drem_q[k-1];
      assign q_in    = dq_q[k-1];
      assign side_in = dside_q[k-1];
    end

    assign sh = 56'(side_in.dv) << Bit;

    always_comb begin
      rem_nx = rem_in;
      q_nx   = q_in;
      for (int l = 0; l < 2; l++) begin
        if (rem_in[l] >= sh) begin
          rem_nx[l]    = rem_in[l] - sh;
          q_nx[l][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dq_q[k]    <= q_nx;
        dside_q[k] <= side_in;
      end
    end

    if (k < DivSteps - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en) begin
          drem_q[k] <= rem_nx;
        end
      end
    end
  end

  // Output register: setpoint x and y are the target pulled back toward the robot; z stays at the target.
  dv_side_t           fs;
  logic signed [42:0] spx [2];
  logic [31:0]        sp  [2];
  pts_pkg::pts_out_t  out_q;

  assign fs = dside_q[DivSteps-1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (fs.neg[l]) begin
        spx[l] = $signed(fs.tw[l]) + $signed({20'h00000, dq_q[DivSteps-1][l]});
      end else begin
        spx[l] = $signed(fs.tw[l]) - $signed({20'h00000, dq_q[DivSteps-1][l]});
      end
      sp[l] = fs.skip ? fs.tw[l] : pts_pkg::sat32(spx[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.target_world_x <= fs.tw[0];
      out_q.target_world_y <= fs.tw[1];
      out_q.target_world_z <= fs.tw[2];
      out_q.setpoint_x     <= sp[0];
      out_q.setpoint_y     <= sp[1];
      out_q.setpoint_z     <= fs.tw[2];
      out_q.zero_distance  <= fs.skip;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: design/pose_transform_standoff_setpoint.sv
// Top level: target pose transform with standoff setpoint, config registers and queue.
//
// Input channel in_valid_i/in_ready_o carries one pose and camera point per item;
// output channel out_valid_o/out_ready_i carries the world target and the setpoint.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i) for the
// standoff distance and the camera mount offsets; index 3 is ignored.
// One item is taken per cycle while the receiver does not stall. Each item passes
// through one front register, the queue and a 64-stage back pipeline whose length
// is set by the 32-stage square root and the 23-stage divider, both fully
// pipelined.
// When the receiver stalls, the back pipeline holds as a whole; the queue and the
// front register keep taking items until they fill, then in_ready_o drops.
// Reset clears all valid state and loads the configuration reset values.
module pose_transform_standoff_setpoint #(
  parameter int unsigned QueueDepth = pts_pkg::QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pts_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pts_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  pts_pkg::pts_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pts_pkg::pts_out_t                 out_data_o
);

  pts_pkg::pts_cfg_t  cfg_q, cfg_d;
  logic               push_valid, push_ready, pop_valid, pop_ready;
  pts_pkg::pts_work_t push_data, pop_data;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (pts_pkg::pts_cfg_idx_e'(cfg_idx_i))
        pts_pkg::CFG_STANDOFF:   cfg_d.standoff = cfg_data_i;
        pts_pkg::CFG_FWD_OFFSET: cfg_d.fwd      = cfg_data_i[17:0];
        pts_pkg::CFG_UP_OFFSET:  cfg_d.up       = cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.standoff <= pts_pkg::STANDOFF_RST;
      cfg_q.fwd      <= pts_pkg::FWD_RST;
      cfg_q.up       <= pts_pkg::UP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  pts_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  pts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: design/pts_checker.sv
// Port-level checks of the pose transform block and their bind to the top level.
module pts_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input pts_pkg::pts_out_t out_data_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // Without a direction the setpoint must sit on the target.
  a_zero_sp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_distance |->
      out_data_o.setpoint_x == out_data_o.target_world_x &&
      out_data_o.setpoint_y == out_data_o.target_world_y)
    else $error("zero distance item has a pulled back setpoint");

  a_sp_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.setpoint_z == out_data_o.target_world_z)
    else $error("setpoint z differs from target z");

endmodule

bind pose_transform_standoff_setpoint pts_checker u_pts_checker (.*);

FILE: sim/pose_transform_standoff_setpoint_checker.sv
// Checker for the pose transform block: predicts each result and compares it.
`timescale 1ns / 100ps
module pose_transform_standoff_setpoint_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [22:0]       cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  pts_pkg::pts_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  pts_pkg::pts_out_t out_data_i,
  output int                fail_count_o,
  output int                pending_o
);

  logic [22:0]        standoff_q;
  logic signed [17:0] fwd_q;
  logic signed [17:0] up_q;
  pts_pkg::pts_out_t  expected_results[$];

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic pts_pkg::pts_out_t predict_setpoint(pts_pkg::pts_in_t it);
    longint pos[3], b[3], rm[9], tw[3], d[3], sp[3];
    longint unsigned mag[3], sum, norm, num, pull_u;
    longint qx, qy, qz, qw, hi, lo, bh, rot, pull;
    bit zero;
    pts_pkg::pts_out_t r;
    pos[0] = it.robot_x; pos[1] = it.robot_y; pos[2] = it.robot_z;
    qx = it.quat_x; qy = it.quat_y; qz = it.quat_z; qw = it.quat_w;
    b[0] = longint'(it.cam_point_z) + fwd_q;
    b[1] = -longint'(it.cam_point_x);
    b[2] = -longint'(it.cam_point_y) + up_q;
    rm[0] = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
    rm[1] = 2 * (qx * qy - qz * qw);
    rm[2] = 2 * (qx * qz + qy * qw);
    rm[3] = 2 * (qx * qy + qz * qw);
    rm[4] = (64'sd1 <<< 28) - 2 * (qx * qx + qz * qz);
    rm[5] = 2 * (qy * qz - qx * qw);
    rm[6] = 2 * (qx * qz - qy * qw);
    rm[7] = 2 * (qy * qz + qx * qw);
    rm[8] = (64'sd1 <<< 28) - 2 * (qx * qx + qy * qy);
    for (int i = 0; i < 3; i++) begin
      hi = 0;
      lo = 0;
      for (int j = 0; j < 3; j++) begin
        bh = floor_shift(b[j], 16);
        hi += rm[3 * i + j] * bh;
        lo += rm[3 * i + j] * (b[j] - bh * 65536);
      end
      rot = floor_shift(hi + floor_shift(lo, 16) + 2048, 12);
      tw[i] = clamp32(rot + pos[i]);
    end
    zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      d[i] = tw[i] - pos[i];
      mag[i] = d[i] < 0 ? -d[i] : d[i];
      if (mag[i] != 0) zero = 1'b0;
      sp[i] = tw[i];
    end
    if (!zero) begin
      // Halve all components when one would overflow the 64-bit square sum.
      if (mag[0] >= 64'd1 << 31 || mag[1] >= 64'd1 << 31 || mag[2] >= 64'd1 << 31)
        for (int i = 0; i < 3; i++) mag[i] >>= 1;
      sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      norm = int_sqrt(sum);
      if (norm != 0) begin
        for (int i = 0; i < 2; i++) begin
          num = longint'(standoff_q) * mag[i];
          pull_u = (2 * num + norm) / (2 * norm);
          pull = d[i] < 0 ? -longint'(pull_u) : longint'(pull_u);
          sp[i] = clamp32(tw[i] - pull);
        end
      end
    end
    r.target_world_x = tw[0][31:0];
    r.target_world_y = tw[1][31:0];
    r.target_world_z = tw[2][31:0];
    r.setpoint_x = sp[0][31:0];
    r.setpoint_y = sp[1][31:0];
    r.setpoint_z = sp[2][31:0];
    r.zero_distance = zero;
    return r;
  endfunction

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, actual %0d", name, e, a);
      fail_count_o++;
    end
  endtask

  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    pts_pkg::pts_out_t e;
    if (!rst_ni) begin
      standoff_q <= pts_pkg::STANDOFF_RST;
      fwd_q <= pts_pkg::FWD_RST;
      up_q <= pts_pkg::UP_RST;
      fail_count_o = 0;
      expected_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no item waiting");
          fail_count_o++;
        end else begin
          e = expected_results.pop_front();
          check_field("target_world_x", e.target_world_x, out_data_i.target_world_x);
          check_field("target_world_y", e.target_world_y, out_data_i.target_world_y);
          check_field("target_world_z", e.target_world_z, out_data_i.target_world_z);
          check_field("setpoint_x", e.setpoint_x, out_data_i.setpoint_x);
          check_field("setpoint_y", e.setpoint_y, out_data_i.setpoint_y);
          check_field("setpoint_z", e.setpoint_z, out_data_i.setpoint_z);
          check_field("zero_distance", e.zero_distance, out_data_i.zero_distance);
        end
      end
      if (in_valid_i && in_ready_i) expected_results.push_back(predict_setpoint(in_data_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pts_pkg::CFG_STANDOFF:   standoff_q <= cfg_data_i;
          pts_pkg::CFG_FWD_OFFSET: fwd_q <= cfg_data_i[17:0];
          pts_pkg::CFG_UP_OFFSET:  up_q <= cfg_data_i[17:0];
          default: ;
        endcase
      end
    end
  end
endmodule

FILE: sim/pose_transform_standoff_setpoint_tb.sv
// Testbench top: drives pose items and configuration, and reports the verdict.
`timescale 1ns / 100ps
module pose_transform_standoff_setpoint_tb;

  localparam int StallLimit = 2000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_idx = '0;
  logic [22:0]       cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  pts_pkg::pts_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  pts_pkg::pts_out_t out_data;
  int                fail_count;
  int                pending;
  int                idle_cycles = 0;
  bit                quiet_tail = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pose_transform_standoff_setpoint DUT (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .in_data_i(in_data), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_data_o(out_data)
  );

  pose_transform_standoff_setpoint_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .in_data_i(in_data), .out_valid_i(out_valid), .out_ready_i(out_ready),
    .out_data_i(out_data), .fail_count_o(fail_count), .pending_o(pending)
  );

  // The receiver stalls in short random bursts until the quiet tail of the run.
  always @(posedge clk) begin
    int burst;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      burst = $urandom_range(1, 3);
      out_ready <= 1'b0;
      repeat (burst) @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(pts_pkg::pts_cfg_idx_e idx, logic [22:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_pipeline();
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_pose(pts_pkg::pts_in_t it);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic end_items();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_quat_comp();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'($urandom);
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      3: return 0;
      default: return 32'($urandom_range(0, 40 << 16)) - (20 << 16);
    endcase
  endfunction

  function automatic pts_pkg::pts_in_t rand_pose();
    pts_pkg::pts_in_t it;
    it.robot_x = rand_coord();
    it.robot_y = rand_coord();
    it.robot_z = rand_coord();
    it.quat_x = rand_quat_comp();
    it.quat_y = rand_quat_comp();
    it.quat_z = rand_quat_comp();
    it.quat_w = rand_quat_comp();
    it.cam_point_x = rand_coord();
    it.cam_point_y = rand_coord();
    it.cam_point_z = rand_coord();
    return it;
  endfunction

  function automatic pts_pkg::pts_in_t make_pose(logic signed [31:0] r,
                                                 logic signed [15:0] qw,
                                                 logic signed [15:0] qx,
                                                 logic signed [31:0] c);
    pts_pkg::pts_in_t it;
    it = '0;
    it.robot_x = r;
    it.robot_y = r;
    it.robot_z = r;
    it.quat_w = qw;
    it.quat_x = qx;
    it.cam_point_x = c;
    it.cam_point_y = c;
    it.cam_point_z = c;
    return it;
  endfunction

  initial begin
    pts_pkg::pts_in_t it;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the reset configuration.
    send_pose(make_pose(0, 16'sd16384, 0, 0));
    send_pose(make_pose(32'sh10000, 16'sd16384, 0, 32'sh20000));
    send_pose(make_pose(32'sh7fffffff, 16'sd16384, 0, 32'sh7fffffff));
    send_pose(make_pose(32'sh80000000, -16'sd16384, 0, 32'sh80000000));
    send_pose(make_pose(32'sh80000000, 16'sd16384, 0, 32'sh7fffffff));
    send_pose(make_pose(0, 16'sh7fff, 16'sh8000, 32'sh7fffffff));
    send_pose(make_pose(0, 16'sd11585, 16'sd11585, 32'sh50000));
    send_pose(make_pose(0, 16'sd8192, 0, 32'sh30000));
    send_pose(make_pose(32'sh12345678, 16'sh8000, 16'sh8000, 32'sh8000_0000));
    send_pose(make_pose(0, 16'hffff, 16'hffff, 32'hffffffff));
    it = make_pose(32'sh40000, 0, 0, 0);
    it.cam_point_z = -32'sd13107;
    it.cam_point_y = 32'sd1966;
    send_pose(it);
    end_items();
    drain_pipeline();

    // Extreme offsets and the largest standoff, then zero distance via a zero
    // body vector and no offsets.
    write_reg(pts_pkg::CFG_FWD_OFFSET, 23'h7fffff & 23'(-18'sd65536));
    write_reg(pts_pkg::CFG_UP_OFFSET, 23'd65536);
    write_reg(pts_pkg::CFG_STANDOFF, 23'd6553600);
    for (int i = 0; i < 5; i++) send_pose(rand_pose());
    send_pose(make_pose(32'sh7fffffff, 16'sd16384, 0, 32'sh80000000));
    end_items();
    drain_pipeline();
    write_reg(pts_pkg::CFG_FWD_OFFSET, 0);
    write_reg(pts_pkg::CFG_UP_OFFSET, 0);
    write_reg(pts_pkg::CFG_STANDOFF, 0);
    send_pose(make_pose(32'sh1000, 16'sd16384, 0, 0));
    send_pose(rand_pose());
    end_items();
    drain_pipeline();
    // Full-width register patterns, beyond the documented ranges.
    write_reg(pts_pkg::CFG_STANDOFF, 23'h7fffff);
    write_reg(pts_pkg::CFG_FWD_OFFSET, 23'h01ffff);
    write_reg(pts_pkg::CFG_UP_OFFSET, 23'h020000);
    send_pose(rand_pose());
    end_items();
    drain_pipeline();

    // Random phases across several configurations.
    for (int phase = 0; phase < 5; phase++) begin
      write_reg(pts_pkg::CFG_STANDOFF, 23'($urandom_range(0, 6553600)));
      write_reg(pts_pkg::CFG_FWD_OFFSET, 23'($urandom));
      write_reg(pts_pkg::CFG_UP_OFFSET, 23'($urandom_range(0, 131072) - 65536));
      if (phase == 4) quiet_tail = 1'b1;
      for (int i = 0; i < 85; i++) send_pose(rand_pose());
      end_items();
      drain_pipeline();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

FILE: sim.f
design/pts_pkg.sv
design/pts_front.sv
design/pts_fifo.sv
design/pts_back.sv
design/pose_transform_standoff_setpoint.sv
design/pts_checker.sv
sim/pose_transform_standoff_setpoint_checker.sv
sim/pose_transform_standoff_setpoint_tb.sv
